[sv/hcmbd_pkg.sv]
package hcmbd_pkg;

	localparam int DMA_BYTES  = 160;
	localparam int ROM_BYTES  = 32768;
	localparam int RAM_DEPTH  = 8192;
	localparam int SPR_DEPTH  = 256;
	localparam int HRAM_DEPTH = 127;
	localparam int ROM_AW     = $clog2(ROM_BYTES);
	localparam int RAM_AW     = $clog2(RAM_DEPTH);

	localparam logic [2:0] OP_RD_BYTE  = 3'd0;
	localparam logic [2:0] OP_WR_BYTE  = 3'd1;
	localparam logic [2:0] OP_RD_WORD  = 3'd2;
	localparam logic [2:0] OP_WR_WORD  = 3'd3;
	localparam logic [2:0] OP_PUSH     = 3'd4;
	localparam logic [2:0] OP_POP      = 3'd5;
	localparam logic [2:0] OP_LOAD_ROM = 3'd6;
	localparam logic [2:0] OP_RESERVED = 3'd7;

	localparam logic [15:0] A_JOYPAD = 16'hFF00;
	localparam logic [15:0] A_DIV    = 16'hFF04;
	localparam logic [15:0] A_IF     = 16'hFF0F;
	localparam logic [15:0] A_LCDC   = 16'hFF40;
	localparam logic [15:0] A_SCY    = 16'hFF42;
	localparam logic [15:0] A_SCX    = 16'hFF43;
	localparam logic [15:0] A_LY     = 16'hFF44;
	localparam logic [15:0] A_DMA    = 16'hFF46;
	localparam logic [15:0] A_HRAM   = 16'hFF80;
	localparam logic [15:0] A_IE     = 16'hFFFF;
	localparam logic [15:0] A_SPR    = 16'hFE00;
	localparam logic [7:0]  LY_VALUE = 8'h90;
	localparam logic [7:0]  JOY_VALUE = 8'hFF;
	localparam logic [7:0]  LFSR_TAPS = 8'hB8;

	typedef enum logic [1:0] {K_NONE, K_READ, K_WRITE, K_LOAD} kind_t;

	typedef enum logic [2:0] {S_CLR, S_IDLE, S_ACC, S_FIN, S_DACC, S_DFIN} state_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] address;
		logic [15:0] data;
		logic [15:0] stack_pointer;
	} req_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic [15:0] new_stack_pointer;
		logic        bad_read;
		logic        bad_write;
	} rsp_t;

	typedef struct packed {
		kind_t       kind;
		logic        two;
		logic [15:0] addr;
		logic [15:0] wdata;
		logic [15:0] nsp;
	} cmd_t;

endpackage

[sv/hcmbd_front.sv]
module hcmbd_front import hcmbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	input  logic clearing,
	input  logic pop,
	output logic busy,
	output cmd_t cmd,
	output logic cmd_valid
);

	cmd_t       dec;
	cmd_t       q_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	// classify the beat into byte accesses
	always_comb begin
		dec.kind  = K_NONE;
		dec.two   = 1'b0;
		dec.addr  = req.address;
		dec.wdata = req.data;
		dec.nsp   = req.stack_pointer;
		case (req.operation)
			OP_RD_BYTE: dec.kind = K_READ;
			OP_WR_BYTE: dec.kind = K_WRITE;
			OP_RD_WORD: begin
				dec.kind = K_READ;
				dec.two  = 1'b1;
			end
			OP_WR_WORD: begin
				dec.kind = K_WRITE;
				dec.two  = 1'b1;
			end
			OP_PUSH: begin
				dec.kind = K_WRITE;
				dec.two  = 1'b1;
				dec.addr = req.stack_pointer - 16'd2;
				dec.nsp  = req.stack_pointer - 16'd2;
			end
			OP_POP: begin
				dec.kind = K_READ;
				dec.two  = 1'b1;
				dec.addr = req.stack_pointer;
				dec.nsp  = req.stack_pointer + 16'd2;
			end
			OP_LOAD_ROM: dec.kind = K_LOAD;
			default: dec.kind = K_NONE;
		endcase
	end

	assign busy      = clearing | (cnt_q == 2'd2);
	assign push      = start & ~busy;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) q_q[wp_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[sv/hcmbd_back.sv]
module hcmbd_back import hcmbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic cmd_valid,
	output logic pop,
	output logic clearing,
	output logic done,
	output rsp_t rsp
);

	state_t state_q, state_n;
	cmd_t   cmd_q;
	logic   b_q;
	logic [7:0] src_q, i_q, lfsr_q;
	logic [7:0] ifl_q, ie_q, lcdc_q, scy_q, scx_q;
	logic [15:0] rd_q, rd_n;
	logic brd_q, brd_n, bwr_q;
	logic [RAM_AW-1:0] clr_q;
	logic done_q;
	rsp_t rsp_q;

	logic [7:0] rom   [ROM_BYTES];
	logic [7:0] vram  [RAM_DEPTH];
	logic [7:0] sram  [RAM_DEPTH];
	logic [7:0] wram  [RAM_DEPTH];
	logic [7:0] spr   [SPR_DEPTH];
	logic [7:0] hram  [HRAM_DEPTH];
	logic [7:0] rom_q, vram_q, sram_q, wram_q, spr_q, hram_q;

	logic        dma, acc_wr, dma_go, more, last, rd_now, clr;
	logic [15:0] a;
	logic [7:0]  wbyte, rb;
	logic        rbad;
	logic        vram_we, sram_we, wram_we, spr_we, hram_we, rom_we;
	logic [RAM_AW-1:0] ram_wa;
	logic [7:0]  ram_wd, spr_wa, spr_wd;
	logic [6:0]  hram_wa;

	assign clr    = (state_q == S_CLR);
	assign dma    = (state_q == S_DACC) || (state_q == S_DFIN);
	assign a      = dma ? {src_q, i_q} : cmd_q.addr + {15'd0, b_q};
	assign wbyte  = b_q ? cmd_q.wdata[15:8] : cmd_q.wdata[7:0];
	assign acc_wr = (state_q == S_ACC) && (cmd_q.kind == K_WRITE);
	assign dma_go = (state_q == S_FIN) && (cmd_q.kind == K_WRITE) && (a == A_DMA);
	assign more   = cmd_q.two && !b_q;
	assign last   = (i_q == 8'(DMA_BYTES - 1));
	assign rd_now = ((state_q == S_FIN) && (cmd_q.kind == K_READ)) || (state_q == S_DFIN);

	// byte read decode
	always_comb begin
		rb   = 8'h00;
		rbad = 1'b0;
		if (!a[15])                       rb = rom_q;
		else if (a[15:13] == 3'b100)      rb = vram_q;
		else if (a[15:13] == 3'b101)      rb = sram_q;
		else if (a < A_SPR)               rb = wram_q;
		else if (a[15:8] == 8'hFE)        rb = spr_q;
		else if (a == A_JOYPAD)           rb = JOY_VALUE;
		else if (a == A_IF)               rb = ifl_q;
		else if (a == A_IE)               rb = ie_q;
		else if (a >= A_HRAM)             rb = hram_q;
		else if (a == A_DIV)              rb = lfsr_q;
		else if (a == A_LCDC)             rb = lcdc_q;
		else if (a == A_SCY)              rb = scy_q;
		else if (a == A_SCX)              rb = scx_q;
		else if (a == A_LY)               rb = LY_VALUE;
		else                              rbad = 1'b1;
	end

	always_comb begin
		rd_n  = rd_q;
		brd_n = brd_q | (rd_now & rbad);
		if (state_q == S_IDLE) begin
			rd_n  = 16'h0000;
			brd_n = 1'b0;
		end else if ((state_q == S_FIN) && (cmd_q.kind == K_READ)) begin
			if (b_q) rd_n[15:8] = rb;
			else     rd_n[7:0]  = rb;
		end
	end

	// memory ports
	assign ram_wa  = clr ? clr_q : a[RAM_AW-1:0];
	assign ram_wd  = clr ? 8'h00 : wbyte;
	assign vram_we = clr | (acc_wr && a[15:13] == 3'b100);
	assign sram_we = clr | (acc_wr && a[15:13] == 3'b101);
	assign wram_we = clr | (acc_wr && a[15:14] == 2'b11 && a < A_SPR);
	assign spr_we  = (clr && clr_q < RAM_AW'(SPR_DEPTH)) | (acc_wr && a[15:8] == 8'hFE)
		| (state_q == S_DFIN);
	assign spr_wa  = clr ? clr_q[7:0] : (dma ? i_q : a[7:0]);
	assign spr_wd  = clr ? 8'h00 : (dma ? rb : wbyte);
	assign hram_we = (clr && clr_q < RAM_AW'(HRAM_DEPTH)) | (acc_wr && a >= A_HRAM && a != A_IE);
	assign hram_wa = clr ? clr_q[6:0] : a[6:0];
	assign rom_we  = (state_q == S_ACC) && (cmd_q.kind == K_LOAD);

	always_ff @(posedge clk) begin
		if (rom_we) rom[cmd_q.addr[ROM_AW-1:0]] <= cmd_q.wdata[7:0];
		rom_q <= rom[a[ROM_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (vram_we) vram[ram_wa] <= ram_wd;
		vram_q <= vram[a[RAM_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (sram_we) sram[ram_wa] <= ram_wd;
		sram_q <= sram[a[RAM_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wram_we) wram[ram_wa] <= ram_wd;
		wram_q <= wram[a[RAM_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (spr_we) spr[spr_wa] <= spr_wd;
		spr_q <= spr[a[7:0]];
	end

	always_ff @(posedge clk) begin
		if (hram_we) hram[hram_wa] <= ram_wd;
		if (a[6:0] != 7'h7F) hram_q <= hram[a[6:0]];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else         state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		pop     = 1'b0;
		case (state_q)
			S_CLR:  if (&clr_q) state_n = S_IDLE;
			S_IDLE: begin
				if (cmd_valid) begin
					pop     = 1'b1;
					state_n = S_ACC;
				end
			end
			S_ACC:  state_n = S_FIN;
			S_FIN: begin
				if (dma_go)    state_n = S_DACC;
				else if (more) state_n = S_ACC;
				else           state_n = S_IDLE;
			end
			S_DACC: state_n = S_DFIN;
			S_DFIN: begin
				if (!last)     state_n = S_DACC;
				else if (more) state_n = S_ACC;
				else           state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) cmd_q <= cmd;
		if (dma_go) src_q <= wbyte;
		rsp_q <= '{read_data: rd_n, new_stack_pointer: cmd_q.nsp,
			bad_read: brd_n, bad_write: bwr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			b_q    <= 1'b0;
			i_q    <= 8'h00;
			rd_q   <= 16'h0000;
			brd_q  <= 1'b0;
			bwr_q  <= 1'b0;
			lfsr_q <= 8'h01;
			ifl_q  <= 8'h00;
			ie_q   <= 8'h00;
			lcdc_q <= 8'h00;
			scy_q  <= 8'h00;
			scx_q  <= 8'h00;
			done_q <= 1'b0;
		end else begin
			done_q <= ((state_q == S_FIN) && !dma_go && !more)
				|| ((state_q == S_DFIN) && last && !more);
			rd_q  <= rd_n;
			brd_q <= brd_n;
			if (clr) clr_q <= clr_q + 1'b1;
			if (state_q == S_IDLE) begin
				b_q   <= 1'b0;
				bwr_q <= 1'b0;
			end
			if (acc_wr) begin
				if (!a[15])       bwr_q  <= 1'b1;
				if (a == A_LCDC)  lcdc_q <= wbyte;
				if (a == A_SCY)   scy_q  <= wbyte;
				if (a == A_SCX)   scx_q  <= wbyte;
				if (a == A_IF)    ifl_q  <= wbyte;
				if (a == A_IE)    ie_q   <= wbyte;
			end
			if (rd_now && a == A_DIV)
				lfsr_q <= (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : 8'h00);
			if (dma_go) i_q <= 8'h00;
			if (state_q == S_DFIN) i_q <= i_q + 8'd1;
			if (((state_q == S_FIN) && !dma_go && more)
				|| ((state_q == S_DFIN) && last && more)) b_q <= 1'b1;
		end
	end

	assign clearing = clr;
	assign done     = done_q;
	assign rsp      = rsp_q;

endmodule

[sv/handheld_console_memory_bus_decoder_unit.sv]
// each item leaves the queue into S_ACC and S_FIN, once per byte for a word or stack
// access; a write that hits the sprite dma register adds S_DACC and S_DFIN per dma byte
// the single byte-wide memory sequencer serves one item at a time; the front queue holds two
// reset: a clearing pass over the rams with busy high; rom is not cleared
// results are strobed for one cycle on done; the receiver cannot stall
module handheld_console_memory_bus_decoder_unit import hcmbd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	cmd_t cmd;
	logic cmd_valid, pop, clearing;

	hcmbd_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .clearing(clearing),
		.pop(pop), .busy(busy), .cmd(cmd), .cmd_valid(cmd_valid)
	);

	hcmbd_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cmd_valid(cmd_valid), .pop(pop),
		.clearing(clearing), .done(done), .rsp(rsp)
	);

endmodule

[sv/hcmbd_checker.sv]
module hcmbd_checker import hcmbd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held two cycles");

	a_write_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.bad_write |-> rsp.read_data == 16'h0000)
		else $error("write beat returned read data");

	a_flags_apart: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.bad_write |-> !rsp.bad_read)
		else $error("both flags raised");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> busy && !done)
		else $error("busy low or result beat during reset");

	a_busy_known: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !$isunknown(busy))
		else $error("busy unknown while start high");

endmodule

bind handheld_console_memory_bus_decoder_unit hcmbd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

[dv/tb_handheld_console_memory_bus_decoder_unit.sv]
`timescale 1ns / 100ps

module tb_handheld_console_memory_bus_decoder_unit;
	import hcmbd_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	handheld_console_memory_bus_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	logic [7:0] rom_mirror [ROM_BYTES];
	bit rom_loaded [ROM_BYTES];
	logic [7:0] vram_mirror [RAM_DEPTH];
	logic [7:0] sram_mirror [RAM_DEPTH];
	logic [7:0] wram_mirror [RAM_DEPTH];
	logic [7:0] spr_mirror [SPR_DEPTH];
	logic [7:0] hram_mirror [HRAM_DEPTH];
	logic [7:0] if_mirror, ie_mirror, lcdc_mirror, scy_mirror, scx_mirror, div_mirror;
	bit rd_flag, wr_flag;

	rsp_t expected_rsp_q [$];
	int fail_count;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] bus_fetch(input logic [15:0] a);
		logic [7:0] v;
		if (a <= 16'h7FFF) return rom_mirror[a[14:0]];
		if (a <= 16'h9FFF) return vram_mirror[a - 16'h8000];
		if (a <= 16'hBFFF) return sram_mirror[a - 16'hA000];
		if (a <= 16'hDFFF) return wram_mirror[a - 16'hC000];
		if (a <= 16'hFDFF) return wram_mirror[a - 16'hE000];
		if (a <= 16'hFEFF) return spr_mirror[a - A_SPR];
		if (a == A_JOYPAD) return JOY_VALUE;
		if (a == A_IF) return if_mirror;
		if (a == A_IE) return ie_mirror;
		if (a >= A_HRAM) return hram_mirror[a - A_HRAM];
		if (a == A_DIV) begin
			v = div_mirror;
			div_mirror = div_mirror >> 1;
			if (v[0]) div_mirror ^= LFSR_TAPS;
			return v;
		end
		if (a == A_LCDC) return lcdc_mirror;
		if (a == A_SCY) return scy_mirror;
		if (a == A_SCX) return scx_mirror;
		if (a == A_LY) return LY_VALUE;
		rd_flag = 1'b1;
		return 8'h00;
	endfunction

	function automatic void bus_store(input logic [15:0] a, input logic [7:0] v);
		logic [15:0] src;
		if (a <= 16'h7FFF) wr_flag = 1'b1;
		else if (a <= 16'h9FFF) vram_mirror[a - 16'h8000] = v;
		else if (a <= 16'hBFFF) sram_mirror[a - 16'hA000] = v;
		else if (a <= 16'hDFFF) wram_mirror[a - 16'hC000] = v;
		else if (a <= 16'hFDFF) wram_mirror[a - 16'hE000] = v;
		else if (a <= 16'hFEFF) spr_mirror[a - A_SPR] = v;
		else if (a == A_LCDC) lcdc_mirror = v;
		else if (a == A_SCY) scy_mirror = v;
		else if (a == A_SCX) scx_mirror = v;
		else if (a == A_DMA) begin
			src = {v, 8'h00};
			for (int i = 0; i < DMA_BYTES && i < 256; i++)
				spr_mirror[i] = bus_fetch(src + 16'(i));
		end
		else if (a == A_IF) if_mirror = v;
		else if (a <= 16'hFF7F) ;
		else if (a <= 16'hFFFE) hram_mirror[a - A_HRAM] = v;
		else ie_mirror = v;
	endfunction

	function automatic rsp_t decode_access(input req_t r);
		rsp_t o;
		logic [15:0] sp;
		logic [7:0] lo;
		sp = r.stack_pointer;
		o = '0;
		rd_flag = 1'b0;
		wr_flag = 1'b0;
		case (r.operation)
			OP_RD_BYTE: o.read_data = {8'h00, bus_fetch(r.address)};
			OP_WR_BYTE: bus_store(r.address, r.data[7:0]);
			OP_RD_WORD: begin
				lo = bus_fetch(r.address);
				o.read_data = {bus_fetch(r.address + 16'd1), lo};
			end
			OP_WR_WORD: begin
				bus_store(r.address, r.data[7:0]);
				bus_store(r.address + 16'd1, r.data[15:8]);
			end
			OP_PUSH: begin
				sp = sp - 16'd2;
				bus_store(sp, r.data[7:0]);
				bus_store(sp + 16'd1, r.data[15:8]);
			end
			OP_POP: begin
				lo = bus_fetch(sp);
				o.read_data = {bus_fetch(sp + 16'd1), lo};
				sp = sp + 16'd2;
			end
			OP_LOAD_ROM: begin
				rom_mirror[r.address[14:0]] = r.data[7:0];
				rom_loaded[r.address[14:0]] = 1'b1;
			end
			default: ;
		endcase
		o.new_stack_pointer = sp;
		o.bad_read = rd_flag;
		o.bad_write = wr_flag;
		return o;
	endfunction

	function automatic bit touches_dma_page(input logic [7:0] page);
		logic [15:0] a;
		for (int i = 0; i < DMA_BYTES; i++) begin
			a = {page, 8'h00} + 16'(i);
			if (a <= 16'h7FFF && !rom_loaded[a[14:0]]) return 1'b1;
		end
		return 1'b0;
	endfunction

	// keep reads of unloaded rom out of the stimulus, dma sources included
	function automatic bit touches_blank_rom(input req_t r);
		logic [15:0] a;
		int n;
		case (r.operation)
			OP_RD_BYTE: begin a = r.address; n = 1; end
			OP_RD_WORD: begin a = r.address; n = 2; end
			OP_POP: begin a = r.stack_pointer; n = 2; end
			OP_WR_BYTE: begin
				if (r.address != A_DMA) return 1'b0;
				a = {r.data[7:0], 8'h00};
				n = DMA_BYTES;
			end
			OP_WR_WORD, OP_PUSH: begin
				a = (r.operation == OP_PUSH) ? r.stack_pointer - 16'd2 : r.address;
				if (a == A_DMA) return touches_dma_page(r.data[7:0]);
				if (a + 16'd1 == A_DMA) return touches_dma_page(r.data[15:8]);
				return 1'b0;
			end
			default: return 1'b0;
		endcase
		for (int i = 0; i < n; i++)
			if (16'(a + i) <= 16'h7FFF && !rom_loaded[16'(a + i) & 16'h7FFF]) return 1'b1;
		return 1'b0;
	endfunction

	function automatic int gap_cycles();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		return n;
	endfunction

	// with no gap start stays high and the next beat follows at once
	task automatic send_beat(input req_t r);
		int n;
		if (touches_blank_rom(r)) begin
			if (start) begin
				start <= 1'b0;
				@(posedge clk);
			end
			return;
		end
		expected_rsp_q.push_back(decode_access(r));
		req <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		n = gap_cycles();
		if (n != 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic req_t make_req(input logic [2:0] op, input logic [15:0] a,
		input logic [15:0] d, input logic [15:0] sp);
		req_t r;
		r.operation = op;
		r.address = a;
		r.data = d;
		r.stack_pointer = sp;
		return r;
	endfunction

	task automatic test_rom_load();
		for (int i = 0; i < ROM_BYTES; i += 128)
			send_beat(make_req(OP_LOAD_ROM, 16'(i) | 16'h8000, 16'($urandom), 16'($urandom)));
		send_beat(make_req(OP_LOAD_ROM, 16'h7FFF, 16'hFFA5, 16'h0000));
		send_beat(make_req(OP_LOAD_ROM, 16'h0000, 16'h005A, 16'hFFFF));
	endtask

	task automatic test_directed();
		send_beat(make_req(OP_RD_BYTE, 16'h0000, 16'h0000, 16'h0000));
		send_beat(make_req(OP_RD_BYTE, 16'h7FFF, 16'hFFFF, 16'hFFFF));
		send_beat(make_req(OP_WR_BYTE, 16'h1234, 16'h00AA, 16'h0000));
		send_beat(make_req(OP_WR_WORD, 16'hC000, 16'hBEEF, 16'h0000));
		send_beat(make_req(OP_RD_WORD, 16'hE000, 16'h0000, 16'h0000));
		send_beat(make_req(OP_RD_BYTE, A_JOYPAD, 16'h0000, 16'h0000));
		send_beat(make_req(OP_RD_BYTE, A_LY, 16'h0000, 16'h0000));
		send_beat(make_req(OP_RD_WORD, A_DIV, 16'h0000, 16'h0000));
		send_beat(make_req(OP_RD_BYTE, A_DIV, 16'h0000, 16'h0000));
		send_beat(make_req(OP_RD_BYTE, 16'hFF01, 16'h0000, 16'h0000));
		send_beat(make_req(OP_WR_BYTE, 16'hFF01, 16'h0077, 16'h0000));
		send_beat(make_req(OP_WR_WORD, A_IE, 16'h1234, 16'h0000));
		send_beat(make_req(OP_RD_WORD, A_IE, 16'h0000, 16'h0000));
		send_beat(make_req(OP_PUSH, 16'h0000, 16'hCAFE, 16'h0001));
		send_beat(make_req(OP_POP, 16'h0000, 16'h0000, 16'hFFFF));
		send_beat(make_req(OP_PUSH, 16'h0000, 16'h1357, 16'hFFFE));
		send_beat(make_req(OP_POP, 16'h0000, 16'h0000, 16'hFFFC));
		send_beat(make_req(OP_WR_BYTE, A_DMA, 16'h00C0, 16'h0000));
		send_beat(make_req(OP_RD_WORD, A_SPR, 16'h0000, 16'h0000));
		send_beat(make_req(OP_WR_BYTE, A_DMA, 16'h00FF, 16'h0000));
		send_beat(make_req(OP_WR_BYTE, A_DMA, 16'h0000, 16'h0000));
		send_beat(make_req(OP_RESERVED, 16'hFFFF, 16'hFFFF, 16'hFFFF));
	endtask

	function automatic logic [15:0] pick_address();
		logic [15:0] hot [12] = '{A_JOYPAD, A_DIV, A_IF, A_LCDC, A_SCY, A_SCX, A_LY,
			A_IE, 16'hFF7F, 16'hFF80, 16'hFFFE, 16'hFE9F};
		case ($urandom_range(0, 5))
			0: return hot[$urandom_range(0, 11)];
			1: return 16'($urandom_range(16'hFF00, 16'hFFFF));
			2: return 16'($urandom_range(16'h8000, 16'h80FF)) | 16'($urandom_range(0, 7) << 13);
			3: return 16'($urandom_range(0, 16'h7FFF));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_random();
		req_t r;
		logic [2:0] op;
		for (int i = 0; i < 1000; i++) begin
			op = ($urandom_range(0, 40) == 0) ? OP_RESERVED : 3'($urandom_range(0, 6));
			r = make_req(op, pick_address(), 16'($urandom), 16'($urandom));
			if ($urandom_range(0, 1)) r.stack_pointer = pick_address();
			if (op == OP_WR_BYTE && $urandom_range(0, 40) == 0) r.address = A_DMA;
			send_beat(r);
		end
	endtask

	always @(posedge clk) begin
		rsp_t e;
		if (done) begin
			if (expected_rsp_q.size() == 0) begin
				$error("result beat with nothing expected");
				fail_count++;
			end else begin
				e = expected_rsp_q.pop_front();
				if (rsp.read_data !== e.read_data) begin
					$error("read_data exp %h got %h", e.read_data, rsp.read_data);
					fail_count++;
				end
				if (rsp.new_stack_pointer !== e.new_stack_pointer) begin
					$error("new_stack_pointer exp %h got %h", e.new_stack_pointer,
						rsp.new_stack_pointer);
					fail_count++;
				end
				if (rsp.bad_read !== e.bad_read) begin
					$error("bad_read exp %b got %b", e.bad_read, rsp.bad_read);
					fail_count++;
				end
				if (rsp.bad_write !== e.bad_write) begin
					$error("bad_write exp %b got %b", e.bad_write, rsp.bad_write);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (done || (start && !busy) || !arst_n) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		fail_count = 0;
		idle_cycles = 0;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		for (int i = 0; i < ROM_BYTES; i++) begin
			rom_mirror[i] = 8'h00;
			rom_loaded[i] = 1'b0;
		end
		for (int i = 0; i < RAM_DEPTH; i++) begin
			vram_mirror[i] = 8'h00;
			sram_mirror[i] = 8'h00;
			wram_mirror[i] = 8'h00;
		end
		for (int i = 0; i < SPR_DEPTH; i++) spr_mirror[i] = 8'h00;
		for (int i = 0; i < HRAM_DEPTH; i++) hram_mirror[i] = 8'h00;
		{if_mirror, ie_mirror, lcdc_mirror, scy_mirror, scx_mirror} = '0;
		div_mirror = 8'h01;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_rom_load();
		test_directed();
		test_random();
		start <= 1'b0;
		while (expected_rsp_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
